>>> src/nsd_pkg.sv
// shared constants, types and the lcg step function for the noise-shaped dither block
`default_nettype none
package nsd_pkg;

  localparam int FRAC_BITS_DEF = 28;
  localparam int OUT_BITS_DEF  = 16;

  localparam int SAMPLE_W = 32;
  localparam int ERR_W    = 32;
  localparam int CNT_W    = 32;
  localparam int LCG_W    = 32;
  // wide enough for sample plus three error taps, bias and dither
  localparam int SUM_W    = 36;

  localparam logic [LCG_W-1:0] LCG_MUL = 32'h0019_660d;
  localparam logic [LCG_W-1:0] LCG_ADD = 32'h3c6e_f35f;

  typedef struct packed {
    logic [LCG_W-1:0] cur;
    logic [LCG_W-1:0] nxt;
  } lcg_pair_t;

  function automatic logic [LCG_W-1:0] lcg_next(input logic [LCG_W-1:0] x);
    logic [LCG_W-1:0] prod;
    prod = x * LCG_MUL;
    return prod + LCG_ADD;
  endfunction

endpackage
`default_nettype wire

>>> src/nsd_lcg.sv
// dither generator: lcg word and its successor, one step ahead of use
`default_nettype none
module nsd_lcg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  output nsd_pkg::lcg_pair_t     lcg
);

  logic [nsd_pkg::LCG_W-1:0] cur;
  logic [nsd_pkg::LCG_W-1:0] nxt;

  // successor is computed from a register, so the multiply never sits in the sample path
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
      nxt <= nsd_pkg::LCG_ADD;
    end else if (step) begin
      cur <= nxt;
      nxt <= nsd_pkg::lcg_next(nxt);
    end
  end

  assign lcg.cur = cur;
  assign lcg.nxt = nxt;

endmodule
`default_nettype wire

>>> src/nsd_core.sv
// noise shaping, dither, clipping, requantisation and level statistics
`default_nettype none
module nsd_core #(
  parameter int FRAC_BITS = nsd_pkg::FRAC_BITS_DEF,
  parameter int OUT_BITS  = nsd_pkg::OUT_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                step,
  input  wire logic signed [nsd_pkg::SAMPLE_W-1:0] sample_in,
  input  wire nsd_pkg::lcg_pair_t                  lcg,
  output logic        [OUT_BITS-1:0]               pcm_next,
  output logic        [FRAC_BITS:0]                peak_level,
  output logic        [nsd_pkg::CNT_W-1:0]         clip_count,
  output logic        [nsd_pkg::CNT_W-1:0]         peak_overshoot
);

  localparam int SW        = nsd_pkg::SUM_W;
  localparam int EW        = nsd_pkg::ERR_W;
  localparam int CW        = nsd_pkg::CNT_W;
  localparam int SCALE_RAW = FRAC_BITS + 1 - OUT_BITS;
  localparam int SCALE     = (SCALE_RAW < 1) ? 1 : SCALE_RAW;

  localparam logic signed [SW-1:0] ONE_V   = signed'(SW'(1) << FRAC_BITS);
  localparam logic signed [SW-1:0] HI_V    = ONE_V - SW'(1);
  localparam logic signed [SW-1:0] LO_V    = -ONE_V;
  localparam logic signed [SW-1:0] BIAS_V  = signed'(SW'(1) << (SCALE - 1));
  localparam logic signed [SW-1:0] SAT_MAX = signed'(SW'(32'h7fff_ffff));
  localparam logic signed [SW-1:0] SAT_MIN = ~SAT_MAX;

  logic signed [EW-1:0] err_newest;
  logic signed [EW-1:0] err_middle;
  logic signed [EW-1:0] err_oldest;
  logic        [FRAC_BITS:0] peak_abs;
  logic        [CW-1:0] clip_total;
  logic        [CW-1:0] overshoot_max;

  logic signed [EW-1:0] err_newest_next;
  logic signed [EW-1:0] err_middle_next;
  logic        [FRAC_BITS:0] peak_abs_next;
  logic        [CW-1:0] clip_total_next;
  logic        [CW-1:0] overshoot_max_next;

  // halving toward zero: add one to negative values before the arithmetic shift
  logic signed [EW:0] half_tmp;
  assign half_tmp        = {err_newest[EW-1], err_newest} + (EW+1)'(err_newest[EW-1]);
  assign err_middle_next = half_tmp[EW:1];

  always_comb begin
    logic signed [SW-1:0] s0;
    logic signed [SW-1:0] o0;
    logic signed [SW-1:0] s;
    logic signed [SW-1:0] o;
    logic signed [SW-1:0] dith;
    logic signed [SW-1:0] peak_ext;
    logic signed [SW-1:0] neg_o;
    logic signed [SW-1:0] excess;
    logic signed [SW-1:0] q;
    logic signed [SW-1:0] qs;
    logic signed [SW-1:0] diff;
    logic        [CW-1:0] ex_sat;
    logic                 clipped;

    s0 = SW'(sample_in) + SW'(err_newest) - SW'(err_middle) + SW'(err_oldest);
    dith = signed'(SW'(lcg.nxt[SCALE-1:0])) - signed'(SW'(lcg.cur[SCALE-1:0]));
    o0 = s0 + BIAS_V + dith;
    peak_ext = signed'(SW'(peak_abs));

    s = s0;
    o = o0;
    excess = '0;
    clipped = 1'b0;
    peak_abs_next = peak_abs;

    if (o0 >= peak_ext) begin
      if (o0 > HI_V) begin
        clipped = 1'b1;
        excess  = o0 - HI_V;
        o       = HI_V;
        if (s0 > HI_V) begin
          s = HI_V;
        end
      end
      peak_abs_next = o[FRAC_BITS:0];
    end else if (o0 < -peak_ext) begin
      if (o0 < LO_V) begin
        clipped = 1'b1;
        excess  = LO_V - o0;
        o       = LO_V;
        if (s0 < LO_V) begin
          s = LO_V;
        end
      end
    end
    neg_o = -o;
    if ((o0 < peak_ext) && (o0 < -peak_ext)) begin
      peak_abs_next = neg_o[FRAC_BITS:0];
    end

    // overshoot saturates at the counter width
    ex_sat = (|excess[SW-1:CW]) ? '1 : excess[CW-1:0];

    clip_total_next    = clip_total;
    overshoot_max_next = overshoot_max;
    if (clipped) begin
      if (clip_total != '1) begin
        clip_total_next = clip_total + CW'(1);
      end
      if (ex_sat > overshoot_max) begin
        overshoot_max_next = ex_sat;
      end
    end

    // drop the bits below one output step
    q = {o[SW-1:SCALE], {SCALE{1'b0}}};
    diff = s - q;
    if (diff > SAT_MAX) begin
      err_newest_next = SAT_MAX[EW-1:0];
    end else if (diff < SAT_MIN) begin
      err_newest_next = SAT_MIN[EW-1:0];
    end else begin
      err_newest_next = diff[EW-1:0];
    end

    qs = q >>> SCALE;
    pcm_next = qs[OUT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err_newest    <= '0;
      err_middle    <= '0;
      err_oldest    <= '0;
      peak_abs      <= '0;
      clip_total    <= '0;
      overshoot_max <= '0;
    end else if (step) begin
      err_newest    <= err_newest_next;
      err_middle    <= err_middle_next;
      err_oldest    <= err_middle;
      peak_abs      <= peak_abs_next;
      clip_total    <= clip_total_next;
      overshoot_max <= overshoot_max_next;
    end
  end

  assign peak_level     = peak_abs;
  assign clip_count     = clip_total;
  assign peak_overshoot = overshoot_max;

endmodule
`default_nettype wire

>>> src/noise_shaped_audio_dither_top.sv
// top level of the noise-shaped dither requantiser
// Takes one signed fixed-point sample (FRAC_BITS fraction bits) per transaction and returns
// one OUT_BITS-wide PCM sample with the running peak level, clip count and peak overshoot.
// Three-tap error feedback shapes the requantisation noise; a high-pass dither taken from
// the low bits of successive lcg words is added with a half-step rounding bias, and the
// result is clipped to plus or minus one before truncation. Throughput is one transaction
// per clock cycle while the receiver keeps out_ready high; each sample passes through the
// input register, then the result register, before its result is valid. The rate is set by
// the error feedback loop, which closes combinationally through the shaping adder, the clip
// compares and the saturation inside nsd_core. Statistics are cumulative from reset
// and are shown with each result; no clearing pass is needed after reset.
`default_nettype none
module noise_shaped_audio_dither_top #(
  parameter int FRAC_BITS = nsd_pkg::FRAC_BITS_DEF,
  parameter int OUT_BITS  = nsd_pkg::OUT_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [nsd_pkg::SAMPLE_W-1:0] sample,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed      [OUT_BITS-1:0]          pcm,
  output logic             [FRAC_BITS:0]           peak_level,
  output logic             [nsd_pkg::CNT_W-1:0]    clip_count,
  output logic             [nsd_pkg::CNT_W-1:0]    peak_overshoot
);

  // input register
  logic                                s1_valid;
  logic signed [nsd_pkg::SAMPLE_W-1:0] s1_sample;

  // one sample moves from the input register into the result register
  logic advance;

  logic [OUT_BITS-1:0] pcm_next;
  nsd_pkg::lcg_pair_t  lcg;

  // advance when the result register is empty or being emptied this cycle
  assign advance  = s1_valid && (!out_valid || out_ready);
  // input register frees itself as it advances, so a new transaction lands every cycle unless the result stalls
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample <= sample;
    end
  end

  // result register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pcm <= signed'(pcm_next);
    end
  end

  // dither source steps once per processed sample
  nsd_lcg u_lcg (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .lcg  (lcg)
  );

  // statistics registers in the core update together with the result register, so they
  // always describe the sample currently held there
  nsd_core #(
    .FRAC_BITS (FRAC_BITS),
    .OUT_BITS  (OUT_BITS)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .sample_in      (s1_sample),
    .lcg            (lcg),
    .pcm_next       (pcm_next),
    .peak_level     (peak_level),
    .clip_count     (clip_count),
    .peak_overshoot (peak_overshoot)
  );

endmodule
`default_nettype wire

>>> src/nsd_checker.sv
// port-level checker for the noise-shaped dither block, with its bind
`default_nettype none
module nsd_checker #(
  parameter int FRAC_BITS = nsd_pkg::FRAC_BITS_DEF,
  parameter int OUT_BITS  = nsd_pkg::OUT_BITS_DEF
) (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic signed [OUT_BITS-1:0]          pcm,
  input wire logic        [FRAC_BITS:0]           peak_level,
  input wire logic        [nsd_pkg::CNT_W-1:0]    clip_count,
  input wire logic        [nsd_pkg::CNT_W-1:0]    peak_overshoot
);

  localparam logic [FRAC_BITS:0] PEAK_MAX = (FRAC_BITS+1)'(1) << FRAC_BITS;

  // a stalled result holds its sample
  a_pcm_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pcm))
    else $error("pcm changed while result stalled");

  // statistics only move when a new result is loaded
  a_stats_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(clip_count) && $stable(peak_level)
      && $stable(peak_overshoot))
    else $error("statistics changed while result stalled");

  // clip count and worst overshoot never fall; the peak may step down from the negative rail
  a_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (clip_count >= $past(clip_count)) && (peak_overshoot >= $past(peak_overshoot)))
    else $error("statistics decreased");

  // peak is bounded by full scale
  a_peak_range: assert property (@(posedge clk) disable iff (rst)
    peak_level <= PEAK_MAX)
    else $error("peak level beyond full scale");

endmodule

bind noise_shaped_audio_dither_top nsd_checker #(
  .FRAC_BITS (FRAC_BITS),
  .OUT_BITS  (OUT_BITS)
) u_nsd_checker (.*);
`default_nettype wire

>>> sim/noise_shaped_audio_dither_top_tb.sv
// self-checking testbench for the noise-shaped dither requantiser top level
module noise_shaped_audio_dither_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // block configuration, taken from the package defaults the instance uses
  localparam int FRAC = nsd_pkg::FRAC_BITS_DEF;
  localparam int OUTB = nsd_pkg::OUT_BITS_DEF;
  localparam int SCALE = (FRAC + 1 - OUTB) < 1 ? 1 : (FRAC + 1 - OUTB);
  localparam int ONE_Q = 1 << FRAC;

  localparam int RANDOM_ITEMS = 700;
  localparam int IDLE_LIMIT   = 2000;  // cycles with no transaction on either side
  localparam int DRAIN_CYCLES = 8;     // wait after the last outstanding result is checked
  localparam int REPORT_MAX   = 10;

  // which fields of a directed row carry a hand-typed expectation
  localparam logic [3:0] KNOWN_NONE  = 4'b0000;
  localparam logic [3:0] KNOWN_PCM   = 4'b0001;
  localparam logic [3:0] KNOWN_PEAK  = 4'b0010;
  localparam logic [3:0] KNOWN_CLIPS = 4'b0100;
  localparam logic [3:0] KNOWN_OVER  = 4'b1000;
  localparam logic [3:0] KNOWN_ALL   = 4'b1111;

  typedef struct packed {
    logic signed [OUTB-1:0]          pcm;
    logic        [FRAC:0]            peak;
    logic        [nsd_pkg::CNT_W-1:0] clips;
    logic        [nsd_pkg::CNT_W-1:0] over;
  } pcm_result_t;

  typedef struct packed {
    logic signed [nsd_pkg::SAMPLE_W-1:0] smp;
    logic        [3:0]                   known;
    pcm_result_t                         typed;
  } sample_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic signed [nsd_pkg::SAMPLE_W-1:0] sample = '0;
  logic in_ready;
  logic out_valid;
  logic signed [OUTB-1:0] pcm;
  logic [FRAC:0] peak_level;
  logic [nsd_pkg::CNT_W-1:0] clip_count;
  logic [nsd_pkg::CNT_W-1:0] peak_overshoot;

  // predictor state: error feedback taps, dither generator and statistics
  longint fb_recent = 0;
  longint fb_mid = 0;
  longint fb_old = 0;
  logic [31:0] dither_word = '0;
  longint peak_mag = 0;
  logic [31:0] clips_seen = '0;
  logic [31:0] worst_excess = '0;

  pcm_result_t pending_pcm[$];
  sample_row_t directed_rows[$];

  int send_idle_pct = 35;
  int recv_stall_pct = 45;
  int n_sent = 0;
  int n_checked = 0;
  int n_err = 0;
  int idle_cycles = 0;

  noise_shaped_audio_dither_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample        (sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pcm           (pcm),
    .peak_level    (peak_level),
    .clip_count    (clip_count),
    .peak_overshoot(peak_overshoot)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // a clipped sample bumps the saturating count and may raise the worst overshoot
  function automatic void log_clip(input longint excess);
    logic [31:0] ex;
    if (clips_seen != 32'hffff_ffff) clips_seen = clips_seen + 1;
    ex = (excess > 64'sd4294967295) ? 32'hffff_ffff : excess[31:0];
    if (ex > worst_excess) worst_excess = ex;
  endfunction

  // one sample through the shaping loop: feedback, bias, dither, clip, truncate
  function automatic pcm_result_t requantise(input logic signed [31:0] smp);
    pcm_result_t r;
    longint s, o, q, msk, lvl;
    logic [31:0] nxt;
    msk = (longint'(1) <<< SCALE) - 1;
    s = longint'(smp) + fb_recent - fb_mid + fb_old;
    fb_old = fb_mid;
    fb_mid = fb_recent / 2;  // truncates toward zero, odd negatives round up
    o = s + (longint'(1) <<< (SCALE - 1));
    // high-pass dither: low bits of the new lcg word minus those of the old one
    nxt = dither_word * nsd_pkg::LCG_MUL + nsd_pkg::LCG_ADD;
    o = o + (longint'({32'd0, nxt}) & msk) - (longint'({32'd0, dither_word}) & msk);
    dither_word = nxt;
    if (o >= peak_mag) begin
      if (o > ONE_Q - 1) begin
        log_clip(o - (ONE_Q - 1));
        o = ONE_Q - 1;
        if (s > ONE_Q - 1) s = ONE_Q - 1;
      end
      peak_mag = o;
    end else if (o < -peak_mag) begin
      if (o < -ONE_Q) begin
        log_clip(-ONE_Q - o);
        o = -ONE_Q;
        if (s < -ONE_Q) s = -ONE_Q;
      end
      peak_mag = -o;
    end
    q = o - (o & msk);
    // stored error saturates to the signed 32-bit range
    if (s - q > 64'sd2147483647) fb_recent = 64'sd2147483647;
    else if (s - q < -64'sd2147483648) fb_recent = -64'sd2147483648;
    else fb_recent = s - q;
    lvl = q >>> SCALE;
    r.pcm = lvl[OUTB-1:0];
    r.peak = peak_mag[FRAC:0];
    r.clips = clips_seen;
    r.over = worst_excess;
    return r;
  endfunction

  function automatic sample_row_t dir_row(input logic signed [31:0] smp,
                                          input logic [3:0] known,
                                          input longint pcm_v, input longint peak_v,
                                          input longint clips_v, input longint over_v);
    sample_row_t row;
    row.smp = smp;
    row.known = known;
    row.typed.pcm = pcm_v[OUTB-1:0];
    row.typed.peak = peak_v[FRAC:0];
    row.typed.clips = clips_v[31:0];
    row.typed.over = over_v[31:0];
    return row;
  endfunction

  // random mix: mostly in range, some around the clip bounds, some wild, some tiny
  function automatic logic signed [31:0] random_sample();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return int'($urandom_range(0, 2 * ONE_Q - 1)) - ONE_Q;
    if (sel < 65) return ($urandom_range(0, 1) ? ONE_Q : -ONE_Q)
                         + int'($urandom_range(0, 16383)) - 8192;
    if (sel < 80) return $urandom;
    return int'($urandom_range(0, 40000)) - 20000;
  endfunction

  task automatic flag(input string what, input longint want, input longint got);
    n_err++;
    if (n_err <= REPORT_MAX)
      $display("mismatch in %s on result %0d: expected %0d, got %0d",
               what, n_checked, want, got);
  endtask

  // offer one transaction, with a random gap first; valid stays up until taken
  task automatic send(input logic signed [31:0] smp);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      sample <= $urandom;  // junk on the bus while idle
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= smp;
    do @(posedge clk); while (!in_ready);
  endtask

  // receiver stalls at the rate of the current phase
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // predict on every input transaction, check every output transaction
  always @(posedge clk) begin
    pcm_result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        want = requantise(sample);
        // hand-typed fields of directed rows take precedence over the predictor
        if (n_sent < directed_rows.size()) begin
          if (directed_rows[n_sent].known & KNOWN_PCM) want.pcm = directed_rows[n_sent].typed.pcm;
          if (directed_rows[n_sent].known & KNOWN_PEAK)
            want.peak = directed_rows[n_sent].typed.peak;
          if (directed_rows[n_sent].known & KNOWN_CLIPS)
            want.clips = directed_rows[n_sent].typed.clips;
          if (directed_rows[n_sent].known & KNOWN_OVER)
            want.over = directed_rows[n_sent].typed.over;
        end
        pending_pcm.push_back(want);
        n_sent++;
      end
      if (out_valid && out_ready) begin
        if (pending_pcm.size() == 0) begin
          n_err++;
          if (n_err <= REPORT_MAX)
            $display("result with nothing outstanding: pcm %0d, peak %0d", pcm, peak_level);
        end else begin
          want = pending_pcm.pop_front();
          if (pcm !== want.pcm) flag("pcm", want.pcm, pcm);
          if (peak_level !== want.peak) flag("peak_level", want.peak, peak_level);
          if (clip_count !== want.clips) flag("clip_count", want.clips, clip_count);
          if (peak_overshoot !== want.over) flag("peak_overshoot", want.over, peak_overshoot);
        end
        n_checked++;
      end
    end
  end

  // watchdog: too long without any transaction means the block has hung
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("noise_shaped_audio_dither_top_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // first sample after reset: dither from the first lcg step, one output step up
    directed_rows.push_back(dir_row(32'sd0, KNOWN_ALL, 1, 9055, 0, 0));
    // small values to walk the peak tracker both ways and through its dead band
    directed_rows.push_back(dir_row(32'sd100000, KNOWN_NONE, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(-32'sd50000, KNOWN_NONE, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(32'sd1000000, KNOWN_NONE, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(-32'sd3000000, KNOWN_NONE, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(32'sd500, KNOWN_NONE, 0, 0, 0, 0));
    // odd negative errors exercise the halving toward zero
    directed_rows.push_back(dir_row(-32'sd1, KNOWN_NONE, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(-32'sd8193, KNOWN_NONE, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(32'sd12345, KNOWN_NONE, 0, 0, 0, 0));
    // around the upper bound, where bias and dither decide on clipping
    directed_rows.push_back(dir_row(32'sh0fff_f000, KNOWN_NONE, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(32'sh1000_0000, KNOWN_NONE, 0, 0, 0, 0));
    // full-scale extremes: clipped to the rails, peak lands on the bound
    directed_rows.push_back(dir_row(32'sh7fff_ffff, KNOWN_PCM | KNOWN_PEAK,
                                    32767, ONE_Q - 1, 0, 0));
    directed_rows.push_back(dir_row(32'sh8000_0000, KNOWN_PCM | KNOWN_PEAK,
                                    -32768, ONE_Q, 0, 0));
    directed_rows.push_back(dir_row(32'shf000_0000, KNOWN_NONE, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(32'shefff_f000, KNOWN_NONE, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(32'sd0, KNOWN_NONE, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(32'sh5555_5555, KNOWN_PCM | KNOWN_PEAK,
                                    32767, ONE_Q - 1, 0, 0));
    directed_rows.push_back(dir_row(32'shaaaa_aaaa, KNOWN_PCM | KNOWN_PEAK,
                                    -32768, ONE_Q, 0, 0));
    directed_rows.push_back(dir_row(32'sh0fff_ffff, KNOWN_NONE, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(32'sh4000_0000, KNOWN_NONE, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(32'shc000_0001, KNOWN_NONE, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(-32'sd4097, KNOWN_NONE, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(32'sd4095, KNOWN_NONE, 0, 0, 0, 0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send(directed_rows[i].smp);

    // three idling phases: receiver-heavy, sender-heavy, then flat out
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        send_idle_pct = 45;
        recv_stall_pct = 35;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      send(random_sample());
    end
    in_valid <= 1'b0;

    while (pending_pcm.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d samples (%0d directed), compared %0d results",
             n_sent, directed_rows.size(), n_checked);
    $display("clipped samples %0d, worst overshoot %0d, final peak %0d, mismatches %0d",
             clips_seen, worst_excess, peak_mag, n_err);
    if (n_err == 0) begin
      $display("noise_shaped_audio_dither_top_tb: done, clean");
    end else begin
      $display("noise_shaped_audio_dither_top_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
src/nsd_pkg.sv
src/nsd_lcg.sv
src/nsd_core.sv
src/noise_shaped_audio_dither_top.sv
src/nsd_checker.sv
sim/noise_shaped_audio_dither_top_tb.sv
